[sv/dpp_pkg.sv]
// Shared widths, register indexes and record types for the depth pixel to point pipeline.
`default_nettype none

package dpp_pkg;

    // Field widths of the stream payloads
    localparam int PIXEL_W     = 12;
    localparam int DEPTH_RAW_W = 16;
    localparam int COLOR_W     = 8;
    localparam int OUT_W       = 33;
    localparam int Z_W         = 16;
    localparam int S_DATA_W    = 64;
    localparam int M_DATA_W    = 112;

    // Register widths
    localparam int CENTER_W = 16;
    localparam int INV_W    = 25;
    localparam int LIMIT_W  = 16;
    localparam int THR_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_THRESHOLD = 3'd5;

    // Register reset values
    localparam logic [CENTER_W-1:0] CENTER_X_RST    = 16'd10917;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 16'd4078;
    localparam logic [INV_W-1:0]    INV_FOCAL_X_RST = 25'd17123;
    localparam logic [INV_W-1:0]    INV_FOCAL_Y_RST = 25'd17795;
    localparam logic [LIMIT_W-1:0]  DEPTH_LIMIT_RST = 16'd4096;
    localparam logic [THR_W-1:0]    COLOR_THR_RST   = 10'd10;

    // Bits of row, column and depth that take part in the math
    localparam int COORD_BITS = 12;
    localparam int DEPTH_BITS = 16;
    localparam int COORD_W = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;
    localparam int DEPTH_W = (DEPTH_BITS < DEPTH_RAW_W) ? DEPTH_BITS : DEPTH_RAW_W;

    // Datapath widths
    localparam int FRAC_SHIFT = 24;
    localparam int MAG_W  = ((COORD_W + 4) > CENTER_W) ? (COORD_W + 4) : CENTER_W;
    localparam int P1_W   = MAG_W + DEPTH_W;
    localparam int HALF_W = P1_W / 2;
    localparam int HI_W   = P1_W - HALF_W;
    localparam int PPL_W  = HALF_W + INV_W;
    localparam int PPH_W  = HI_W + INV_W;
    localparam int PROD_W = P1_W + INV_W;
    localparam int SP_W   = PROD_W + 1;
    localparam int Q_W    = SP_W - FRAC_SHIFT;
    localparam int SAT_W  = (Q_W > OUT_W) ? Q_W : (OUT_W + 1);

    // Front register plus five stages in each axis unit
    localparam int NUM_STAGES = 6;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [LIMIT_W-1:0]  depth_limit;
        logic [THR_W-1:0]    color_threshold;
    } cfg_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } pay_t;

    typedef struct packed {
        logic             neg_x;
        logic [MAG_W-1:0] mag_x;
        logic             neg_y;
        logic [MAG_W-1:0] mag_y;
        pay_t             pay;
    } front_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctrl_t;

endpackage

`default_nettype wire

[sv/dpp_cfg.sv]
// Configuration register file for the depth pixel to point pipeline.
`default_nettype none

module dpp_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dpp_pkg::CFG_DATA_W-1:0] cfg_data,
    output dpp_pkg::cfg_t                       cfg
);
    import dpp_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x        <= CENTER_X_RST;
            cfg_reg.center_y        <= CENTER_Y_RST;
            cfg_reg.inv_focal_x     <= INV_FOCAL_X_RST;
            cfg_reg.inv_focal_y     <= INV_FOCAL_Y_RST;
            cfg_reg.depth_limit     <= DEPTH_LIMIT_RST;
            cfg_reg.color_threshold <= COLOR_THR_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_X:        cfg_reg.center_x        <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:        cfg_reg.center_y        <= cfg_data[CENTER_W-1:0];
                REG_INV_FOCAL_X:     cfg_reg.inv_focal_x     <= cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:     cfg_reg.inv_focal_y     <= cfg_data[INV_W-1:0];
                REG_DEPTH_LIMIT:     cfg_reg.depth_limit     <= cfg_data[LIMIT_W-1:0];
                REG_COLOR_THRESHOLD: cfg_reg.color_threshold <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/dpp_front.sv]
// Input stage: pixel filter and signed offset of the pixel from the principal point.
`default_nettype none

module dpp_front (
    input  wire logic                            aclk,
    input  wire dpp_pkg::stage_ctrl_t            ctrl,
    input  wire dpp_pkg::cfg_t                   cfg,
    input  wire logic [dpp_pkg::PIXEL_W-1:0]     pixel_row,
    input  wire logic [dpp_pkg::PIXEL_W-1:0]     pixel_col,
    input  wire logic [dpp_pkg::DEPTH_RAW_W-1:0] depth_raw,
    input  wire logic [dpp_pkg::COLOR_W-1:0]     blue_in,
    input  wire logic [dpp_pkg::COLOR_W-1:0]     green_in,
    input  wire logic [dpp_pkg::COLOR_W-1:0]     red_in,
    output logic                                 keep,
    output dpp_pkg::front_t                      front
);
    import dpp_pkg::*;

    front_t front_reg;
    front_t front_next;

    logic [DEPTH_W-1:0] depth;
    logic [THR_W-1:0]   color_sum;
    logic [MAG_W:0]     diff_x;
    logic [MAG_W:0]     diff_y;
    logic [MAG_W:0]     abs_x;
    logic [MAG_W:0]     abs_y;

    assign depth = depth_raw[DEPTH_W-1:0];

    always_comb begin
        color_sum = THR_W'(blue_in) + THR_W'(green_in) + THR_W'(red_in);
        keep = (depth != '0)
            && (LIMIT_W'(depth) < cfg.depth_limit)
            && (color_sum > cfg.color_threshold);

        // coordinate in Q4 minus center, one bit wider to hold the sign
        diff_x = (MAG_W+1)'({pixel_col[COORD_W-1:0], 4'b0000}) - (MAG_W+1)'(cfg.center_x);
        diff_y = (MAG_W+1)'({pixel_row[COORD_W-1:0], 4'b0000}) - (MAG_W+1)'(cfg.center_y);
        abs_x  = diff_x[MAG_W] ? ((MAG_W+1)'(0) - diff_x) : diff_x;
        abs_y  = diff_y[MAG_W] ? ((MAG_W+1)'(0) - diff_y) : diff_y;

        front_next.neg_x     = diff_x[MAG_W];
        front_next.mag_x     = abs_x[MAG_W-1:0];
        front_next.neg_y     = diff_y[MAG_W];
        front_next.mag_y     = abs_y[MAG_W-1:0];
        front_next.pay.depth = depth;
        front_next.pay.blue  = blue_in;
        front_next.pay.green = green_in;
        front_next.pay.red   = red_in;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

[sv/dpp_axis.sv]
// Five-stage projection of one axis: multiply by depth and reciprocal focal, floor, saturate.
`default_nettype none

module dpp_axis (
    input  wire logic                        aclk,
    input  wire dpp_pkg::stage_ctrl_t        ctrl,
    input  wire logic                        neg_in,
    input  wire logic [dpp_pkg::MAG_W-1:0]   mag_in,
    input  wire logic [dpp_pkg::DEPTH_W-1:0] depth_in,
    input  wire logic [dpp_pkg::INV_W-1:0]   inv_focal,
    output logic [dpp_pkg::OUT_W-1:0]        point_out
);
    import dpp_pkg::*;

    logic               neg1_reg, neg2_reg, neg3_reg;
    logic [P1_W-1:0]    p1_reg;
    logic [PPL_W-1:0]   ppl_reg;
    logic [PPH_W-1:0]   pph_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [SP_W-1:0]    sp_reg;
    logic [SP_W-1:0]    sp_next;
    logic [SP_W-1:0]    sp_ext;
    logic [OUT_W-1:0]   out_reg;
    logic [OUT_W-1:0]   out_next;
    logic signed [Q_W-1:0]   q;
    logic signed [SAT_W-1:0] qx;

    always_comb begin
        prod_next = {pph_reg, {HALF_W{1'b0}}} + PROD_W'(ppl_reg);
        sp_ext    = {1'b0, prod_reg};
        sp_next   = neg3_reg ? (SP_W'(0) - sp_ext) : sp_ext;

        // arithmetic shift floors toward minus infinity
        q  = $signed(sp_reg[SP_W-1:FRAC_SHIFT]);
        qx = SAT_W'(q);
        if ((&qx[SAT_W-1:OUT_W-1]) || !(|qx[SAT_W-1:OUT_W-1])) begin
            out_next = qx[OUT_W-1:0];
        end else if (qx[SAT_W-1]) begin
            out_next = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            out_next = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            neg1_reg <= neg_in;
            p1_reg   <= P1_W'(mag_in) * P1_W'(depth_in);
        end
        // split the wide product into two narrow partial products
        if (ctrl.load[2]) begin
            neg2_reg <= neg1_reg;
            ppl_reg  <= PPL_W'(p1_reg[HALF_W-1:0]) * PPL_W'(inv_focal);
            pph_reg  <= PPH_W'(p1_reg[P1_W-1:HALF_W]) * PPH_W'(inv_focal);
        end
        if (ctrl.load[3]) begin
            neg3_reg <= neg2_reg;
            prod_reg <= prod_next;
        end
        if (ctrl.load[4]) begin
            sp_reg <= sp_next;
        end
        if (ctrl.load[5]) begin
            out_reg <= out_next;
        end
    end

    assign point_out = out_reg;

endmodule

`default_nettype wire

[sv/depth_pixel_to_point_top.sv]
// Top level of the RGB-D pixel back-projection pipeline.
//
//  Channel  Dir  Signals                                   Contents
//  s_       in   s_tvalid s_tready s_tdata[63:0]           one RGB-D pixel
//  m_       out  m_tvalid m_tready m_tdata[111:0]          one 3D point with colour
//  cfg_     in   cfg_valid cfg_ready cfg_index cfg_data    register write
//
//  A pixel passes the front register and then the axis stages before m_tvalid; one pixel
//  per cycle sustained while m_tready stays high. The axis stages, each with its own
//  register, are the two multiplies, the wide add, the negate and shift-and-saturate.
//  Rejected pixels leave no trace after the front stage.
//  Each stage loads when empty or when the stage after it advances, so bubbles close up
//  and a stall on m_tready holds every stage without loss.
//  aresetn clears the valid bits and restores the register defaults.
`default_nettype none

module depth_pixel_to_point_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // pixel_row[11:0], pixel_col[23:12], depth_raw[39:24],
    // blue_in[47:40], green_in[55:48], red_in[63:56]
    input  wire logic [dpp_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // point_x[32:0], point_y[65:33], point_z[81:66],
    // blue_out[89:82], green_out[97:90], red_out[105:98], zero[111:106]
    output logic [dpp_pkg::M_DATA_W-1:0]        m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dpp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dpp_pkg::*;

    cfg_t        cfg;
    stage_ctrl_t ctrl;
    front_t      front;
    logic        keep;

    logic [NUM_STAGES-1:0] valid_reg;
    pay_t                  pay_reg [1:NUM_STAGES-1];
    logic [OUT_W-1:0]      point_x;
    logic [OUT_W-1:0]      point_y;

    dpp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // load chain runs from the output back to the input
    always_comb begin
        ctrl.load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ctrl.load[k] = !valid_reg[k] || ctrl.load[k+1];
        end
    end

    assign s_tready = ctrl.load[0];

    dpp_front u_front (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .cfg       (cfg),
        .pixel_row (s_tdata[11:0]),
        .pixel_col (s_tdata[23:12]),
        .depth_raw (s_tdata[39:24]),
        .blue_in   (s_tdata[47:40]),
        .green_in  (s_tdata[55:48]),
        .red_in    (s_tdata[63:56]),
        .keep      (keep),
        .front     (front)
    );

    dpp_axis u_axis_x (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .neg_in    (front.neg_x),
        .mag_in    (front.mag_x),
        .depth_in  (front.pay.depth),
        .inv_focal (cfg.inv_focal_x),
        .point_out (point_x)
    );

    dpp_axis u_axis_y (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .neg_in    (front.neg_y),
        .mag_in    (front.mag_y),
        .depth_in  (front.pay.depth),
        .inv_focal (cfg.inv_focal_y),
        .point_out (point_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            // drop a rejected pixel at the front stage
            if (ctrl.load[0]) begin
                valid_reg[0] <= s_tvalid && keep;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (ctrl.load[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // depth and colour ride along with the axis stages
    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            pay_reg[1] <= front.pay;
        end
        for (int k = 2; k < NUM_STAGES; k++) begin
            if (ctrl.load[k]) begin
                pay_reg[k] <= pay_reg[k-1];
            end
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {6'b000000,
                       pay_reg[NUM_STAGES-1].red,
                       pay_reg[NUM_STAGES-1].green,
                       pay_reg[NUM_STAGES-1].blue,
                       Z_W'(pay_reg[NUM_STAGES-1].depth),
                       point_y,
                       point_x};

endmodule

`default_nettype wire

[tb/depth_pixel_to_point_top_tb.sv]
// Self-checking bench for depth_pixel_to_point_top: directed and random pixels.

module depth_pixel_to_point_top_tb;

    import dpp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned SETTLE      = NUM_STAGES + 2;

    // Indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam longint COORD_MAX = 64'sd4294967295;
    localparam longint COORD_MIN = -64'sd4294967296;
    localparam logic signed [OUT_W-1:0] SAT_HIGH = 33'sh0_FFFF_FFFF;
    localparam logic signed [OUT_W-1:0] SAT_LOW  = 33'sh1_0000_0000;

    typedef struct packed {
        logic [PIXEL_W-1:0]     row;
        logic [PIXEL_W-1:0]     col;
        logic [DEPTH_RAW_W-1:0] depth;
        logic [COLOR_W-1:0]     blue;
        logic [COLOR_W-1:0]     green;
        logic [COLOR_W-1:0]     red;
    } pixel_t;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic [Z_W-1:0]          z;
        logic [COLOR_W-1:0]      blue;
        logic [COLOR_W-1:0]      green;
        logic [COLOR_W-1:0]      red;
    } point_t;

    typedef struct {
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [INV_W-1:0]    ifx;
        logic [INV_W-1:0]    ify;
        logic [LIMIT_W-1:0]  lim;
        logic [THR_W-1:0]    thr;
    } camera_t;

    typedef enum {DIR_PIXEL, DIR_REG} dir_kind_t;
    typedef enum {OUT_DROP, OUT_TYPED, OUT_MODEL} outcome_t;

    typedef struct {
        dir_kind_t               kind;
        outcome_t                how;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        pixel_t                  px;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    camera_t cam = '{CENTER_X_RST, CENTER_Y_RST, INV_FOCAL_X_RST, INV_FOCAL_Y_RST,
                     DEPTH_LIMIT_RST, COLOR_THR_RST};

    point_t      points_due[$];
    dir_row_t    dir_tab[$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_period   = 1;
    int unsigned rx_phase    = 0;
    int unsigned rx_open     = 1;

    depth_pixel_to_point_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic add_row(input dir_row_t d);
        dir_tab.insert(dir_tab.size(), d);
    endtask

    task automatic expect_point(input point_t pt);
        points_due.insert(points_due.size(), pt);
    endtask

    // Offset from the principal point, scaled by depth and 1/f, floored and clamped
    function automatic logic signed [OUT_W-1:0] scaled_offset(
        input logic [PIXEL_W-1:0] coord, input logic [CENTER_W-1:0] center,
        input logic [DEPTH_RAW_W-1:0] depth, input logic [INV_W-1:0] inv_f);
        longint off;
        longint prod;
        longint q;
        off  = longint'({coord, 4'b0000}) - longint'(center);
        prod = off * longint'(depth) * longint'(inv_f);
        q    = prod >>> FRAC_SHIFT;
        if (q > COORD_MAX) begin
            q = COORD_MAX;
        end else if (q < COORD_MIN) begin
            q = COORD_MIN;
        end
        return q[OUT_W-1:0];
    endfunction

    function automatic bit backproject(input pixel_t px, output point_t pt);
        int color_sum;
        color_sum = int'(px.blue) + int'(px.green) + int'(px.red);
        pt.x      = scaled_offset(px.col, cam.cx, px.depth, cam.ifx);
        pt.y      = scaled_offset(px.row, cam.cy, px.depth, cam.ify);
        pt.z      = px.depth;
        pt.blue   = px.blue;
        pt.green  = px.green;
        pt.red    = px.red;
        return px.depth != 0 && px.depth < cam.lim && color_sum > int'(cam.thr);
    endfunction

    function automatic dir_row_t dir_pixel(
        input logic [PIXEL_W-1:0] row, input logic [PIXEL_W-1:0] col,
        input logic [DEPTH_RAW_W-1:0] depth, input logic [COLOR_W-1:0] b,
        input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r, input outcome_t how,
        input logic signed [OUT_W-1:0] x = '0, input logic signed [OUT_W-1:0] y = '0);
        dir_row_t d;
        d.kind    = DIR_PIXEL;
        d.how     = how;
        d.reg_idx = '0;
        d.reg_val = '0;
        d.px      = '{row, col, depth, b, g, r};
        d.x       = x;
        d.y       = y;
        return d;
    endfunction

    function automatic dir_row_t dir_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        dir_row_t d;
        d         = dir_pixel('0, '0, '0, '0, '0, '0, OUT_DROP);
        d.kind    = DIR_REG;
        d.reg_idx = idx;
        d.reg_val = val;
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_reg_value(input logic [CFG_IDX_W-1:0] idx);
        int unsigned pick;
        pick = $urandom_range(0, 5);
        if (pick == 2) begin
            return {CFG_DATA_W{1'b1}};
        end
        case (idx)
            REG_CENTER_X, REG_CENTER_Y: begin
                if (pick == 0) return '0;
                if (pick == 1) return 25'd65535;
                return CFG_DATA_W'($urandom_range(0, 65535));
            end
            REG_INV_FOCAL_X, REG_INV_FOCAL_Y: begin
                if (pick == 0) return '0;
                if (pick == 1) return 25'd16777216;
                if (pick == 3) return CFG_DATA_W'($urandom_range(0, 65535));
                return CFG_DATA_W'($urandom_range(0, 16777216));
            end
            REG_DEPTH_LIMIT: begin
                if (pick == 0) return 25'd1;
                if (pick == 1) return 25'd65535;
                return CFG_DATA_W'($urandom_range(2, 65535));
            end
            default: begin
                if (pick == 0) return '0;
                if (pick == 1) return 25'd765;
                return CFG_DATA_W'($urandom_range(0, 300));
            end
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        px.row = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 12'd4095 : 12'd0)
                                             : PIXEL_W'($urandom_range(0, 4095));
        px.col = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 12'd4095 : 12'd0)
                                             : PIXEL_W'($urandom_range(0, 4095));
        case ($urandom_range(0, 9))
            0: px.depth = '0;
            1: px.depth = cam.lim;
            2: px.depth = DEPTH_RAW_W'($urandom_range(0, 65535));
            3: px.depth = 16'hFFFF;
            default: px.depth = (cam.lim > 1) ? DEPTH_RAW_W'($urandom_range(1, cam.lim - 1))
                                              : DEPTH_RAW_W'($urandom_range(0, 65535));
        endcase
        // dark pixels sit near the color threshold
        if ($urandom_range(0, 9) == 0) begin
            px.blue  = COLOR_W'($urandom_range(0, 4));
            px.green = COLOR_W'($urandom_range(0, 4));
            px.red   = COLOR_W'($urandom_range(0, 4));
        end else begin
            px.blue  = COLOR_W'($urandom_range(0, 255));
            px.green = COLOR_W'($urandom_range(0, 255));
            px.red   = COLOR_W'($urandom_range(0, 255));
        end
        return px;
    endfunction

    // Leaves cfg_valid high when hold is set so the next write follows without a gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (!hold) begin
            cfg_valid <= 1'b0;
        end
        case (idx)
            REG_CENTER_X:        cam.cx  = val[CENTER_W-1:0];
            REG_CENTER_Y:        cam.cy  = val[CENTER_W-1:0];
            REG_INV_FOCAL_X:     cam.ifx = val[INV_W-1:0];
            REG_INV_FOCAL_Y:     cam.ify = val[INV_W-1:0];
            REG_DEPTH_LIMIT:     cam.lim = val[LIMIT_W-1:0];
            REG_COLOR_THRESHOLD: cam.thr = val[THR_W-1:0];
            default: ;
        endcase
    endtask

    // Returns at the edge that takes the pixel; s_tvalid stays high
    task automatic push_pixel(input pixel_t px);
        s_tvalid <= 1'b1;
        s_tdata  <= {px.red, px.green, px.blue, px.depth, px.col, px.row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_points_out();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (points_due.size() != 0) @(posedge aclk);
        // a dropped pixel may still sit in the front stage
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Receiver: ready while rx_phase is below rx_open; rx_period and rx_open are redrawn when a period ends
    always @(posedge aclk) begin
        int unsigned per;
        if (rx_phase + 1 >= rx_period) begin
            per = $urandom_range(1, 16);
            rx_period <= per;
            rx_phase  <= 0;
            case ($urandom_range(0, 3))
                0: rx_open <= per;
                1: rx_open <= 0;
                default: rx_open <= $urandom_range(0, per);
            endcase
        end else begin
            rx_phase <= rx_phase + 1;
        end
        m_tready <= (rx_phase < rx_open);
    end

    always @(posedge aclk) begin
        point_t got;
        point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x     = m_tdata[32:0];
            got.y     = m_tdata[65:33];
            got.z     = m_tdata[81:66];
            got.blue  = m_tdata[89:82];
            got.green = m_tdata[97:90];
            got.red   = m_tdata[105:98];
            if (points_due.size() == 0) begin
                flag_mismatch($sformatf("point x=%0d y=%0d z=%0d with none due",
                                        got.x, got.y, got.z));
            end else begin
                want = points_due.pop_front();
                if (got.x !== want.x)
                    flag_mismatch($sformatf("point_x %0d, want %0d", got.x, want.x));
                if (got.y !== want.y)
                    flag_mismatch($sformatf("point_y %0d, want %0d", got.y, want.y));
                if (got.z !== want.z)
                    flag_mismatch($sformatf("point_z %0d, want %0d", got.z, want.z));
                if (got.blue !== want.blue)
                    flag_mismatch($sformatf("blue_out %0d, want %0d", got.blue, want.blue));
                if (got.green !== want.green)
                    flag_mismatch($sformatf("green_out %0d, want %0d", got.green, want.green));
                if (got.red !== want.red)
                    flag_mismatch($sformatf("red_out %0d, want %0d", got.red, want.red));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        dir_row_t             r;
        pixel_t               px;
        point_t               pt;
        logic [CFG_IDX_W-1:0] reg_order[6];
        int                   i;
        int                   k;
        int                   n;
        int                   phase_len;
        int                   gap;
        int                   burst_left;
        int                   sent;

        reg_order  = '{REG_CENTER_X, REG_CENTER_Y, REG_INV_FOCAL_X, REG_INV_FOCAL_Y,
                       REG_DEPTH_LIMIT, REG_COLOR_THRESHOLD};
        burst_left = 0;
        sent       = 0;

        // Reset register values: depth and color rejections, small negative floor
        add_row(dir_pixel(10, 20, 0, 255, 255, 255, OUT_DROP));
        add_row(dir_pixel(10, 20, 4096, 255, 255, 255, OUT_DROP));
        add_row(dir_pixel(10, 20, 65535, 255, 255, 255, OUT_DROP));
        add_row(dir_pixel(10, 20, 100, 3, 3, 4, OUT_DROP));
        add_row(dir_pixel(0, 0, 100, 3, 4, 4, OUT_MODEL));
        add_row(dir_pixel(4095, 4095, 4095, 255, 255, 255, OUT_MODEL));
        add_row(dir_pixel(255, 682, 1, 0, 0, 255, OUT_MODEL));
        // Whole-pixel centers and power-of-two focal terms give exact coordinates
        add_row(dir_write(REG_CENTER_X, 25'd1600));
        add_row(dir_write(REG_CENTER_Y, 25'd800));
        add_row(dir_write(REG_INV_FOCAL_X, 25'd16777216));
        add_row(dir_write(REG_INV_FOCAL_Y, 25'd8388608));
        add_row(dir_write(REG_DEPTH_LIMIT, 25'd65535));
        add_row(dir_write(REG_COLOR_THRESHOLD, 25'd0));
        add_row(dir_pixel(50, 100, 1000, 1, 0, 0, OUT_TYPED, 0, 0));
        add_row(dir_pixel(52, 101, 3, 0, 0, 1, OUT_TYPED, 48, 48));
        add_row(dir_pixel(49, 99, 7, 0, 1, 0, OUT_TYPED, -112, -56));
        add_row(dir_pixel(4095, 4095, 65534, 128, 64, 32, OUT_TYPED,
                          33'sd4188933280, 33'sd2120680240));
        add_row(dir_pixel(7, 7, 5, 0, 0, 0, OUT_DROP));
        add_row(dir_pixel(0, 0, 1, 0, 0, 1, OUT_TYPED, -1600, -400));
        add_row(dir_pixel(7, 7, 65535, 9, 9, 9, OUT_DROP));
        // Oversized write data is cut to register width; full-scale focal saturates
        add_row(dir_write(REG_CENTER_X, 25'h1FFFFFF));
        add_row(dir_write(REG_CENTER_Y, 25'h1FF0000));
        add_row(dir_write(REG_INV_FOCAL_X, 25'h1FFFFFF));
        add_row(dir_write(REG_INV_FOCAL_Y, 25'h1FFFFFF));
        add_row(dir_pixel(4095, 0, 65534, 255, 255, 255, OUT_TYPED,
                          SAT_LOW, SAT_HIGH));
        add_row(dir_pixel(0, 4095, 1, 1, 1, 1, OUT_MODEL));
        add_row(dir_write(REG_COLOR_THRESHOLD, 25'd1023));
        add_row(dir_pixel(9, 9, 100, 255, 255, 255, OUT_DROP));
        add_row(dir_write(REG_DEPTH_LIMIT, 25'd0));
        add_row(dir_pixel(9, 9, 1, 255, 255, 255, OUT_DROP));
        add_row(dir_write(REG_SPARE_A, 25'h1FFFFFF));
        add_row(dir_write(REG_SPARE_B, 25'h1FFFFFF));
        add_row(dir_write(REG_DEPTH_LIMIT, 25'd2));
        add_row(dir_write(REG_COLOR_THRESHOLD, 25'd2));
        add_row(dir_pixel(4095, 4095, 1, 1, 1, 1, OUT_MODEL));
        add_row(dir_pixel(4095, 4095, 2, 1, 1, 1, OUT_DROP));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < dir_tab.size(); i++) begin
            r = dir_tab[i];
            if (r.kind == DIR_REG) begin
                if (i > 0 && dir_tab[i-1].kind == DIR_PIXEL) begin
                    wait_points_out();
                end
                write_reg(r.reg_idx, r.reg_val,
                          i + 1 < dir_tab.size() && dir_tab[i+1].kind == DIR_REG);
            end else begin
                push_pixel(r.px);
                sent++;
                case (r.how)
                    OUT_MODEL: begin
                        if (backproject(r.px, pt)) expect_point(pt);
                    end
                    OUT_TYPED: begin
                        pt.x     = r.x;
                        pt.y     = r.y;
                        pt.z     = r.px.depth;
                        pt.blue  = r.px.blue;
                        pt.green = r.px.green;
                        pt.red   = r.px.red;
                        expect_point(pt);
                    end
                    default: ;
                endcase
            end
        end

        // Random phases, each under a fresh camera setting written while drained
        while (sent < 700) begin
            wait_points_out();
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_W'($urandom()), 1'b1);
            end
            for (k = 0; k < 6; k++) begin
                write_reg(reg_order[k], rand_reg_value(reg_order[k]), k < 5);
            end
            phase_len = $urandom_range(60, 140);
            for (n = 0; n < phase_len; n++) begin
                if (burst_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: gap = 0;
                        1: gap = $urandom_range(1, 3);
                        2: gap = $urandom_range(4, 20);
                        default: gap = $urandom_range(0, 1);
                    endcase
                    if (gap > 0) begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                    burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
                end
                px = rand_pixel();
                push_pixel(px);
                burst_left--;
                sent++;
                if (backproject(px, pt)) expect_point(pt);
            end
        end

        wait_points_out();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[depth_pixel_to_point_top.f]
sv/dpp_pkg.sv
sv/dpp_cfg.sv
sv/dpp_front.sv
sv/dpp_axis.sv
sv/depth_pixel_to_point_top.sv
tb/depth_pixel_to_point_top_tb.sv
